/* src/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

	localparam int CMD_W   = 2;
	localparam int WORD_W  = 64;
	localparam int ORD_W   = 2;
	localparam int IDX_W   = 8;
	localparam int TOTAL_W = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [ORD_W-1:0] {
		ORD_EMPTY    = 2'd0,
		ORD_ASC      = 2'd1,
		ORD_DESC     = 2'd2,
		ORD_UNSORTED = 2'd3
	} ord_t;

	typedef enum logic [1:0] {
		ASEL_LO,
		ASEL_HI,
		ASEL_MID
	} addr_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_RLO,
		ST_RHI,
		ST_RMID,
		ST_STEP,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic      start;
		logic      clear;
		logic      append;
		logic      rd_en;
		addr_sel_t rd_sel;
		logic      narrow;
		logic      set_found;
		logic      load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic searchable;
		logic hit;
		logic span_small;
	} dp_sts_t;

endpackage

`default_nettype wire

/* src/stbs_req_if.sv */
// ----------------------------------------------------------------------------
// stbs_req_if
// Request channel: command and packed key word.
// ----------------------------------------------------------------------------
`default_nettype none

interface stbs_req_if
	import stbs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [WORD_W-1:0] word;

	modport source (output valid, output cmd, output word, input ready);
	modport sink (input valid, input cmd, input word, output ready);
endinterface

`default_nettype wire

/* src/stbs_rsp_if.sv */
// ----------------------------------------------------------------------------
// stbs_rsp_if
// Response channel: order status, search result and table fill.
// ----------------------------------------------------------------------------
`default_nettype none

interface stbs_rsp_if
	import stbs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [ORD_W-1:0]   order_status;
	logic               found;
	logic [IDX_W-1:0]   index;
	logic [TOTAL_W-1:0] entry_total;
	logic               table_full;

	modport source (output valid, output order_status, output found, output index,
		output entry_total, output table_full, input ready);
	modport sink (input valid, input order_status, input found, input index,
		input entry_total, input table_full, output ready);
endinterface

`default_nettype wire

/* src/stbs_dpath.sv */
// ----------------------------------------------------------------------------
// stbs_dpath
// Key table memory, order tracking, search bounds and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_dpath
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_CHARS   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [WORD_W-1:0]  word,
	input  wire ctl_cmd_t           cmd,
	output dp_sts_t                 sts,
	output logic [ORD_W-1:0]        order_status,
	output logic                    found,
	output logic [IDX_W-1:0]        index,
	output logic [TOTAL_W-1:0]      entry_total,
	output logic                    table_full
);

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W  = 8 * KEY_CHARS;

	logic [KEY_W-1:0]   mem [TABLE_DEPTH];

	logic [CNT_W-1:0]   count_q;
	logic [KEY_W-1:0]   prev_q;
	logic               asc_q;
	logic               desc_q;
	logic               found_q;
	logic               full_q;
	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   rd_q;
	logic [ADDR_W-1:0]  lo_q;
	logic [ADDR_W-1:0]  hi_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  idx_q;

	logic [ORD_W-1:0]   ord_q;
	logic               found_out_q;
	logic [IDX_W-1:0]   index_q;
	logic [TOTAL_W-1:0] total_q;
	logic               full_out_q;

	logic [KEY_W-1:0]   word_k;
	logic               is_full;
	ord_t               status;
	logic [ADDR_W-1:0]  span;
	logic [ADDR_W-1:0]  mid;
	logic [ADDR_W-1:0]  raddr;
	logic               go_low;

	assign word_k  = word[KEY_W-1:0];
	assign is_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign span    = hi_q - lo_q;
	assign mid     = lo_q + (span >> 1);

	always_comb begin
		if (count_q == '0) begin
			status = ORD_EMPTY;
		end else if (count_q == CNT_W'(1) || asc_q) begin
			status = ORD_ASC;
		end else if (desc_q) begin
			status = ORD_DESC;
		end else begin
			status = ORD_UNSORTED;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			ASEL_LO:  raddr = lo_q;
			ASEL_HI:  raddr = hi_q;
			default:  raddr = mid;
		endcase
	end

	// mirrored compare for descending tables
	assign go_low = (status == ORD_DESC) ? (rd_q < key_q) : (rd_q > key_q);

	assign sts.searchable = (status == ORD_ASC) || (status == ORD_DESC);
	assign sts.hit        = (rd_q == key_q);
	assign sts.span_small = (span <= ADDR_W'(1));

	// table memory
	always_ff @(posedge clk) begin
		if (cmd.append && !is_full) begin
			mem[count_q[ADDR_W-1:0]] <= word_k;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev_q  <= '0;
			asc_q   <= 1'b1;
			desc_q  <= 1'b1;
			found_q <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				found_q <= 1'b0;
				full_q  <= cmd.append && is_full;
			end
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.clear) begin
				count_q <= '0;
				prev_q  <= '0;
				asc_q   <= 1'b1;
				desc_q  <= 1'b1;
			end else if (cmd.append && !is_full) begin
				if (count_q != '0) begin
					if (!(word_k > prev_q)) asc_q <= 1'b0;
					if (!(word_k < prev_q)) desc_q <= 1'b0;
				end
				prev_q  <= word_k;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= word_k;
			lo_q  <= '0;
			hi_q  <= ADDR_W'(count_q - CNT_W'(1));
			idx_q <= '0;
		end
		if (cmd.rd_en) begin
			addr_q <= raddr;
		end
		if (cmd.set_found) begin
			idx_q <= addr_q;
		end
		if (cmd.narrow) begin
			if (go_low) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid;
			end
		end
		if (cmd.load_out) begin
			ord_q       <= status;
			found_out_q <= found_q;
			index_q     <= IDX_W'(idx_q);
			total_q     <= TOTAL_W'(count_q);
			full_out_q  <= full_q;
		end
	end

	assign order_status = ord_q;
	assign found        = found_out_q;
	assign index        = index_q;
	assign entry_total  = total_q;
	assign table_full   = full_out_q;

endmodule

`default_nettype wire

/* src/stbs_ctrl.sv */
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller: command decode, probe sequencing and response handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl
	import stbs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic [CMD_W-1:0] req_cmd,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output ctl_cmd_t              cmd,
	input  wire dp_sts_t          sts
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					unique case (cmd_t'(req_cmd))
						CMD_CLEAR: begin
							cmd.clear = 1'b1;
							state_d   = ST_RESP;
						end
						CMD_APPEND: begin
							cmd.append = 1'b1;
							state_d    = ST_RESP;
						end
						CMD_SEARCH: begin
							state_d = ST_CHK;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_CHK: begin
				if (sts.searchable) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ASEL_LO;
					state_d    = ST_RLO;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RLO: begin
				if (sts.hit) begin
					cmd.set_found = 1'b1;
					state_d       = ST_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ASEL_HI;
					state_d    = ST_RHI;
				end
			end
			ST_RHI: begin
				if (sts.hit) begin
					cmd.set_found = 1'b1;
					state_d       = ST_RESP;
				end else if (sts.span_small) begin
					state_d = ST_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ASEL_MID;
					state_d    = ST_RMID;
				end
			end
			ST_RMID: begin
				if (sts.hit) begin
					cmd.set_found = 1'b1;
					state_d       = ST_RESP;
				end else begin
					cmd.narrow = 1'b1;
					state_d    = ST_STEP;
				end
			end
			ST_STEP: begin
				if (sts.span_small) begin
					state_d = ST_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ASEL_MID;
					state_d    = ST_RMID;
				end
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* src/sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Key table with order tracking and binary search over the stored keys.
//
//   channel  dir  handshake       word contents
//   req      in   valid / ready   cmd, word
//   rsp      out  valid / ready   order_status, found, index, entry_total,
//                                 table_full
//
// clear, append and unused commands go from accept straight to the response state.
// a search of a sorted table probes the low bound, then the high bound, then
// midpoints until a match or a span of at most one; an empty or unsorted table
// goes straight to the response. each probe is a registered table read then a compare.
// the response register lets the next word be accepted while a result waits.
// reset clears count and order flags; table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_CHARS   = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stbs_req_if.sink    req,
	stbs_rsp_if.source  rsp
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	stbs_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_CHARS   (KEY_CHARS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.word         (req.word),
		.cmd          (cmd),
		.sts          (sts),
		.order_status (rsp.order_status),
		.found        (rsp.found),
		.index        (rsp.index),
		.entry_total  (rsp.entry_total),
		.table_full   (rsp.table_full)
	);

endmodule

`default_nettype wire

/* src/stbs_checker.sv */
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks on the response channel of the search block.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_checker
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic [ORD_W-1:0]   order_status,
	input wire logic               found,
	input wire logic [TOTAL_W-1:0] entry_total,
	input wire logic               table_full
);

	// a pending word stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before taken");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_total <= TABLE_DEPTH)
		else $error("entry total beyond table depth");

	a_found_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found |-> (order_status == ORD_ASC || order_status == ORD_DESC))
		else $error("match reported on unsorted or empty table");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && table_full |-> entry_total == TOTAL_W'(TABLE_DEPTH) && !found)
		else $error("table full flag with table not full");

endmodule

bind sorted_table_binary_search stbs_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_stbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.order_status (rsp.order_status),
	.found        (rsp.found),
	.entry_total  (rsp.entry_total),
	.table_full   (rsp.table_full)
);

`default_nettype wire
